>>> src/hlpi_pkg.sv
// Shared types, constants and the hash fold function of the hashed linear-probe insert block.
package hlpi_pkg;

    localparam int HASH_W      = 32;
    localparam int KEY_W       = 8;
    localparam int HANDLE_IN_W = 32;
    localparam int SLOT_IDX_W  = 6;
    localparam int SLOTS_REG_W = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int MIX_SHIFT   = 15;

    localparam logic [HASH_W-1:0]      MIX_MULT    = 32'h5bd1e995;
    localparam logic [HASH_W-1:0]      SEED_RESET  = 32'h12345678;
    localparam logic [SLOTS_REG_W-1:0] SLOTS_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED   = 2'd1;

    // Result status codes
    localparam logic STATUS_INSERTED = 1'b0;
    localparam logic STATUS_FULL     = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]       key_byte;
        logic                   byte_valid;
        logic                   key_last;
        logic [HANDLE_IN_W-1:0] entry_handle;
    } t_in_item;

    typedef struct packed {
        logic                  status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [HASH_W-1:0]     key_hash;
    } t_out_item;

    // Fold one byte into the running hash: xor, multiply, xor with shifted self.
    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [KEY_W-1:0]  b);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] p;
        x = h ^ {{(HASH_W-KEY_W){1'b0}}, b};
        p = x * MIX_MULT;
        return p ^ (p >> MIX_SHIFT);
    endfunction

endpackage

>>> src/hlpi_rem_unit.sv
// Bit-serial remainder unit: one dividend bit per cycle, hash modulo slot count.
module hlpi_rem_unit #(
    parameter int DIV_W = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hlpi_pkg::HASH_W-1:0]    i_dividend,
    input  logic [DIV_W-1:0]               i_divisor,
    output logic                           o_done,
    output logic [DIV_W-1:0]               o_rem
);

    localparam int STEP_W = $clog2(hlpi_pkg::HASH_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(hlpi_pkg::HASH_W - 1);

    logic                        r_run;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [hlpi_pkg::HASH_W-1:0] r_dvd;
    logic [DIV_W-1:0]            r_rem;
    logic [DIV_W-1:0]            n_rem;
    logic [DIV_W:0]              w_trial;

    // Shift in the next dividend bit, subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[hlpi_pkg::HASH_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_trial = w_trial - {1'b0, i_divisor};
        end
        n_rem = w_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_run && (r_step == LAST_STEP);
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> src/hashed_linear_probe_insert.sv
// Top level: byte-stream Murmur hash with linear-probe insert into an open-addressing table.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+-----------------------------------
//  item in  | start, busy, i_item                     | taken when start & !busy
//  result   | o_done, o_result                        | one-cycle strobe, cannot be held
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata        | written when i_cfg_we, no wait
//
// Flow: a key byte without key_last is folded into the hash on the accepting edge, and busy
// stays low. A key_last transaction runs the bit-serial remainder unit over the hash, takes
// its result, then spends a registered valid-memory read and then a check on each probe.
// o_done rises after the last probe, or right after the remainder result when the table is
// full up front; busy falls on that same edge, so the next transaction can be taken only
// once the result of the previous key_last is out.
// Reset: synchronous, active low; after reset a clearing pass writes every valid bit to
// zero, one slot a cycle, with busy high. Config writes are taken during that pass. The
// receiver cannot stall; each result is valid on o_result in the cycle in which o_done is
// high.
module hashed_linear_probe_insert #(
    parameter int TABLE_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  hlpi_pkg::t_in_item                 i_item,
    output logic                               o_done,
    output hlpi_pkg::t_out_item                o_result,
    input  logic                               i_cfg_we,
    input  logic [hlpi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hlpi_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int XW    = (CNT_W > hlpi_pkg::SLOTS_REG_W) ? CNT_W : hlpi_pkg::SLOTS_REG_W;
    localparam int HW    = hlpi_pkg::HASH_W;

    // Control state
    hlpi_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr_addr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done, n_done;

    // Configuration and hash accumulator
    logic [hlpi_pkg::SLOTS_REG_W-1:0] r_table_slots;
    logic [HW-1:0]                    r_seed;
    logic [HW-1:0]                    r_hash;

    // Per-key payload
    logic [HW-1:0]                    r_key_hash;
    logic [hlpi_pkg::HANDLE_IN_W-1:0] r_handle;
    logic [IDX_W-1:0]                 r_pos, n_pos;
    logic [CNT_W-1:0]                 r_n, n_n;
    hlpi_pkg::t_out_item              r_result, n_result;

    // Table storage
    logic                    r_valid_mem [TABLE_DEPTH];
    logic [HANDLE_WIDTH-1:0] r_handle_mem [TABLE_DEPTH];
    logic                    r_rd_valid;
    logic                    w_vld_we;
    logic [IDX_W-1:0]        w_vld_addr;
    logic                    w_vld_wdata;
    logic                    w_hdl_we;

    // Datapath helpers
    logic                          w_accept;
    logic [HW-1:0]                 w_folded;
    logic [XW-1:0]                 w_slots_x;
    logic [CNT_W-1:0]              w_slots;
    logic [CNT_W-1:0]              w_pos_inc;
    logic [CNT_W-1:0]              w_n_inc;
    logic                          w_full_now;
    logic                          w_rem_done;
    logic [CNT_W-1:0]              w_rem;
    logic [IDX_W+hlpi_pkg::SLOT_IDX_W-1:0] w_pos_ext;
    logic [HANDLE_WIDTH+hlpi_pkg::HANDLE_IN_W-1:0] w_hdl_ext;

    assign w_accept = start && !busy;

    // Fold the current byte, or keep the hash for an empty key.
    assign w_folded = i_item.byte_valid ? hlpi_pkg::fold_byte(r_hash, i_item.key_byte)
                                        : r_hash;

    // Saturate the slot count to 2..TABLE_DEPTH.
    always_comb begin
        w_slots_x = XW'(r_table_slots);
        if (w_slots_x < XW'(2)) begin
            w_slots_x = XW'(2);
        end else if (w_slots_x > XW'(TABLE_DEPTH)) begin
            w_slots_x = XW'(TABLE_DEPTH);
        end
        w_slots = w_slots_x[CNT_W-1:0];
    end

    assign w_pos_inc  = CNT_W'(r_pos) + CNT_W'(1);
    assign w_n_inc    = r_n + CNT_W'(1);
    // One slot always stays free: full once count + 1 reaches the slot count.
    assign w_full_now = ({1'b0, r_count} + (CNT_W+1)'(1)) >= {1'b0, w_slots};
    assign w_pos_ext  = {{hlpi_pkg::SLOT_IDX_W{1'b0}}, r_pos};
    assign w_hdl_ext  = {{HANDLE_WIDTH{1'b0}}, r_handle};

    // Home slot = hash mod slot count, one bit per cycle.
    hlpi_rem_unit #(
        .DIV_W(CNT_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && i_item.key_last),
        .i_dividend (w_folded),
        .i_divisor  (w_slots),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hlpi_pkg::S_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = hlpi_pkg::S_IDLE;
                end
            end
            hlpi_pkg::S_IDLE: begin
                if (w_accept && i_item.key_last) begin
                    n_state = hlpi_pkg::S_MOD;
                end
            end
            hlpi_pkg::S_MOD: begin
                if (w_rem_done) begin
                    n_state = w_full_now ? hlpi_pkg::S_IDLE : hlpi_pkg::S_RD;
                end
            end
            hlpi_pkg::S_RD: begin
                n_state = hlpi_pkg::S_CHK;
            end
            hlpi_pkg::S_CHK: begin
                if (!r_rd_valid || (w_n_inc == w_slots)) begin
                    n_state = hlpi_pkg::S_IDLE;
                end else begin
                    n_state = hlpi_pkg::S_RD;
                end
            end
            default: n_state = hlpi_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        n_pos               = r_pos;
        n_n                 = r_n;
        n_count             = r_count;
        n_done              = 1'b0;
        n_result            = r_result;
        w_vld_we            = 1'b0;
        w_vld_addr          = r_pos;
        w_vld_wdata         = 1'b0;
        w_hdl_we            = 1'b0;
        unique case (r_state)
            hlpi_pkg::S_CLEAR: begin
                w_vld_we   = 1'b1;
                w_vld_addr = r_clr_addr;
            end
            hlpi_pkg::S_IDLE: begin
            end
            hlpi_pkg::S_MOD: begin
                if (w_rem_done) begin
                    n_pos = w_rem[IDX_W-1:0];
                    n_n   = '0;
                    if (w_full_now) begin
                        n_done              = 1'b1;
                        n_result.status     = hlpi_pkg::STATUS_FULL;
                        n_result.slot_index = '0;
                        n_result.key_hash   = r_key_hash;
                    end
                end
            end
            hlpi_pkg::S_RD: begin
            end
            hlpi_pkg::S_CHK: begin
                n_result.key_hash = r_key_hash;
                if (!r_rd_valid) begin
                    // Claim the free slot.
                    w_vld_we            = 1'b1;
                    w_vld_wdata         = 1'b1;
                    w_hdl_we            = 1'b1;
                    n_count             = r_count + CNT_W'(1);
                    n_done              = 1'b1;
                    n_result.status     = hlpi_pkg::STATUS_INSERTED;
                    n_result.slot_index = w_pos_ext[hlpi_pkg::SLOT_IDX_W-1:0];
                end else if (w_n_inc == w_slots) begin
                    n_done              = 1'b1;
                    n_result.status     = hlpi_pkg::STATUS_FULL;
                    n_result.slot_index = '0;
                end else begin
                    // Advance with wrap at the slot count.
                    n_pos = (w_pos_inc == w_slots) ? '0 : w_pos_inc[IDX_W-1:0];
                    n_n   = w_n_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hlpi_pkg::S_CLEAR;
            r_clr_addr    <= '0;
            r_count       <= '0;
            r_done        <= 1'b0;
            r_table_slots <= hlpi_pkg::SLOTS_RESET;
            r_seed        <= hlpi_pkg::SEED_RESET;
            r_hash        <= hlpi_pkg::SEED_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (r_state == hlpi_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cfg_we && (i_cfg_idx == hlpi_pkg::REG_TABLE_SLOTS)) begin
                r_table_slots <= i_cfg_wdata[hlpi_pkg::SLOTS_REG_W-1:0];
            end
            // A seed write restarts any key in progress.
            if (i_cfg_we && (i_cfg_idx == hlpi_pkg::REG_HASH_SEED)) begin
                r_seed <= i_cfg_wdata[HW-1:0];
                r_hash <= i_cfg_wdata[HW-1:0];
            end else if (w_accept) begin
                r_hash <= i_item.key_last ? r_seed : w_folded;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_n      <= n_n;
        r_result <= n_result;
        if (w_accept && i_item.key_last) begin
            r_key_hash <= w_folded;
            r_handle   <= i_item.entry_handle;
        end
    end

    // Valid-bit memory: one write port, registered read at the probe position.
    always_ff @(posedge i_clk) begin
        if (w_vld_we) begin
            r_valid_mem[w_vld_addr] <= w_vld_wdata;
        end
        r_rd_valid <= r_valid_mem[r_pos];
    end

    // Handle memory: written on insert only.
    always_ff @(posedge i_clk) begin
        if (w_hdl_we) begin
            r_handle_mem[r_pos] <= w_hdl_ext[HANDLE_WIDTH-1:0];
        end
    end

    assign busy     = (r_state != hlpi_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
